[src/pfh_pkg.sv]
// Shared constants, types and handshake structs for the page free-list max-heap.
package pfh_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned PAGE_BITS  = 32;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_W    = CNT_W + 1;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABOVE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef struct packed {
    logic  push;
    logic  pop;
    page_t data;
  } heap_cmd_t;

  typedef struct packed {
    logic  done;
    page_t data;
  } heap_rsp_t;

endpackage

[src/pfh_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module pfh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/pfh_heap.sv]
// Heap sequencer: push with sift-up and pop with sift-down over the free-page RAM.
module pfh_heap import pfh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  heap_cmd_t        cmd_i,
  output heap_rsp_t        rsp_o,
  output logic [CNT_W-1:0] cnt_o
);

  typedef enum logic [6:0] {
    H_IDLE = 7'b0000001,
    H_UP   = 7'b0000010,
    H_TOP  = 7'b0000100,
    H_LAST = 7'b0001000,
    H_DNR  = 7'b0010000,
    H_DNC  = 7'b0100000,
    H_WR   = 7'b1000000
  } hstate_e;

  hstate_e            state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   par_q, par_d;
  logic [CHILD_W-1:0] lch_q, lch_d;
  page_t              lv_q, lv_d;
  page_t              cur_q, cur_d;
  page_t              top_q, top_d;
  logic               rvld_q, rvld_d;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  page_t              wdata;
  logic [IDX_W-1:0]   raddr;
  page_t              rdata;
  logic               done;

  logic [CHILD_W-1:0] cnt_ext;
  logic [CHILD_W-1:0] rch;
  logic               pick_r;
  logic [CHILD_W-1:0] cidx;
  page_t              cval;
  logic [CHILD_W-1:0] nl;
  logic [IDX_W-1:0]   par_push;
  logic [IDX_W-1:0]   par_up;

  pfh_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cnt_ext  = {1'b0, cnt_q};
  assign rch      = lch_q + CHILD_W'(1);
  // The larger child wins; on a tie the left child is kept.
  assign pick_r   = rvld_q && (rdata > lv_q);
  assign cidx     = pick_r ? rch : lch_q;
  assign cval     = pick_r ? rdata : lv_q;
  assign nl       = {cidx[CHILD_W-2:0], 1'b1};
  assign par_push = IDX_W'((cnt_q[IDX_W-1:0] - IDX_W'(1)) >> 1);
  assign par_up   = IDX_W'((par_q - IDX_W'(1)) >> 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    par_d   = par_q;
    lch_d   = lch_q;
    lv_d    = lv_q;
    cur_d   = cur_q;
    top_d   = top_q;
    rvld_d  = rvld_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = cur_q;
    raddr   = '0;
    done    = 1'b0;

    unique case (state_q)
      H_IDLE: begin
        if (cmd_i.push) begin
          cur_d = cmd_i.data;
          idx_d = cnt_q[IDX_W-1:0];
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_q == '0) begin
            // A lone entry needs no sift; it is written from the holding register.
            state_d = H_WR;
          end else begin
            raddr   = par_push;
            par_d   = par_push;
            state_d = H_UP;
          end
        end else if (cmd_i.pop) begin
          cnt_d   = cnt_q - CNT_W'(1);
          raddr   = '0;
          state_d = H_TOP;
        end
      end
      H_UP: begin
        we = 1'b1;
        if (rdata >= cur_q) begin
          done    = 1'b1;
          state_d = H_IDLE;
        end else begin
          // Parent moves down into the hole; the hole climbs one level.
          wdata = rdata;
          idx_d = par_q;
          if (par_q == '0) begin
            state_d = H_WR;
          end else begin
            raddr = par_up;
            par_d = par_up;
          end
        end
      end
      H_TOP: begin
        top_d = rdata;
        if (cnt_q == '0) begin
          done    = 1'b1;
          state_d = H_IDLE;
        end else begin
          raddr   = cnt_q[IDX_W-1:0];
          state_d = H_LAST;
        end
      end
      H_LAST: begin
        cur_d = rdata;
        idx_d = '0;
        lch_d = CHILD_W'(1);
        if (cnt_ext > CHILD_W'(1)) begin
          raddr   = IDX_W'(1);
          state_d = H_DNR;
        end else begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rdata;
          done    = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_DNR: begin
        lv_d = rdata;
        if (rch < cnt_ext) begin
          raddr  = rch[IDX_W-1:0];
          rvld_d = 1'b1;
        end else begin
          rvld_d = 1'b0;
        end
        state_d = H_DNC;
      end
      H_DNC: begin
        we = 1'b1;
        if (cval > cur_q) begin
          wdata = cval;
          idx_d = cidx[IDX_W-1:0];
          if (nl < cnt_ext) begin
            raddr   = nl[IDX_W-1:0];
            lch_d   = nl;
            state_d = H_DNR;
          end else begin
            state_d = H_WR;
          end
        end else begin
          done    = 1'b1;
          state_d = H_IDLE;
        end
      end
      H_WR: begin
        we      = 1'b1;
        done    = 1'b1;
        state_d = H_IDLE;
      end
      default: begin
        state_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    par_q  <= par_d;
    lch_q  <= lch_d;
    lv_q   <= lv_d;
    cur_q  <= cur_d;
    top_q  <= top_d;
    rvld_q <= rvld_d;
  end

  assign rsp_o.done = done;
  assign rsp_o.data = top_d;
  assign cnt_o      = cnt_q;

endmodule

[src/page_free_list_max_heap_core.sv]
// Page allocator top level: request decode, highest-page counter and result register.
// Latency: requests decided without the heap (fresh allocation or an error) give their
// result one cycle after acceptance and the next may be taken in the following cycle.
// A release walks up the heap at one level per cycle.
// An allocation from the free store takes the root and sifts the last entry down.
// Reset clears the held count and loads the highest page with 0; results cannot be stalled.
module page_free_list_max_heap_core import pfh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             initial_highest_page_we_i,
  input  logic [31:0]      initial_highest_page_i,
  input  logic             start,
  input  logic             req_type_i,
  input  logic [31:0]      page_number_i,
  output logic             busy,
  output logic             done_o,
  output logic [31:0]      granted_page_o,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] free_count_o
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_WAIT = 2'b10
  } tstate_e;

  tstate_e          state_q, state_d;
  page_t            hp_q, hp_d;
  logic             pop_q, pop_d;
  logic             done_q, done_d;
  page_t            gp_q, gp_d;
  status_e          st_q, st_d;
  logic [CNT_W-1:0] fc_q, fc_d;

  heap_cmd_t        cmd;
  heap_rsp_t        rsp;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             above;
  logic             full;

  pfh_heap u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp),
    .cnt_o  (cnt)
  );

  assign accept = start && (state_q == T_IDLE);
  assign above  = page_number_i > hp_q;
  assign full   = cnt == CNT_W'(HEAP_DEPTH);

  assign cmd.push = accept && req_type_i && !above && !full;
  assign cmd.pop  = accept && !req_type_i && (cnt != '0);
  assign cmd.data = page_number_i;

  always_comb begin
    state_d = state_q;
    hp_d    = hp_q;
    pop_d   = pop_q;
    done_d  = 1'b0;
    gp_d    = gp_q;
    st_d    = st_q;
    fc_d    = fc_q;

    unique case (state_q)
      T_IDLE: begin
        if (cmd.push || cmd.pop) begin
          pop_d   = cmd.pop;
          state_d = T_WAIT;
        end else if (accept) begin
          done_d = 1'b1;
          gp_d   = '0;
          st_d   = ST_OK;
          fc_d   = cnt;
          if (req_type_i) begin
            st_d = above ? ST_ABOVE : ST_FULL;
          end else if (hp_q == '1) begin
            st_d = ST_EXHAUSTED;
          end else begin
            hp_d = hp_q + PAGE_BITS'(1);
            gp_d = hp_q + PAGE_BITS'(1);
          end
        end
      end
      T_WAIT: begin
        if (rsp.done) begin
          done_d  = 1'b1;
          gp_d    = pop_q ? rsp.data : '0;
          st_d    = ST_OK;
          fc_d    = cnt;
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase

    // The user must write the highest page only while idle; the block does not enforce this.
    if (initial_highest_page_we_i) begin
      hp_d = initial_highest_page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      hp_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hp_q    <= hp_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pop_q <= pop_d;
    gp_q  <= gp_d;
    st_q  <= st_d;
    fc_q  <= fc_d;
  end

  assign busy           = state_q != T_IDLE;
  assign done_o         = done_q;
  assign granted_page_o = gp_q;
  assign status_o       = st_q;
  assign free_count_o   = fc_q;

endmodule
